>>> design/tws_pkg.sv
// ============================================================================
// tws_pkg: shared types, constants and curve builders of the table waveshaper
// Holds the configuration register indexes, the queue entry kind and the
// elaboration-time functions that compute the two transfer curves.
// ============================================================================
package tws_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIndexW = 4;
  localparam logic [CfgIndexW-1:0] CFG_CURVE_MODE = 4'd0;
  localparam logic [CfgIndexW-1:0] CFG_INPUT_GAIN = 4'd1;

  // Reset values of the configuration registers.
  localparam logic        CURVE_MODE_RESET = 1'b0;
  localparam logic [15:0] INPUT_GAIN_RESET = 16'd4096;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Fraction bits of a table position.
  localparam int unsigned FracW = 28;

  // How an item is to be finished by the back part.
  typedef enum logic [1:0] {
    KIND_INTERP = 2'd0,
    KIND_SAT_LO = 2'd1,
    KIND_SAT_HI = 2'd2
  } tws_kind_e;

  // Shift-and-subtract unsigned division, used only while building the curves.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Product of two Q54 values, truncated back to Q54.
  function automatic logic [63:0] q54_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[117:54];
  endfunction

  // Soft-clip magnitude in Q15 for |x| = au/n.
  function automatic logic [63:0] soft_clip_mag(logic [63:0] au, logic [63:0] n);
    logic [63:0] d;
    logic [63:0] den;
    logic [63:0] q;
    d   = '0;
    den = '0;
    q   = '0;
    if (64'd3 * au > 64'd2 * n) begin
      return 64'd32768;
    end
    if (64'd3 * au > n) begin
      d   = 64'd2 * n - 64'd3 * au;
      den = 64'd3 * n * n;
      q   = udiv64(64'd32768 * d * d + (den >> 1), den);
      return 64'd32768 - q;
    end
    return udiv64(64'd65536 * au + (n >> 1), n);
  endfunction

  // Magnitude of tanh(4*au/n) in Q15, through exp(-8au/n) = exp(-r)^256.
  function automatic logic [63:0] tanh_mag(logic [63:0] au, logic [63:0] n);
    logic [63:0] one;
    logic [63:0] r;
    logic [63:0] r2;
    logic [63:0] r3;
    logic [63:0] r4;
    logic [63:0] r5;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    one = 64'd1 << 54;
    r   = udiv64(au << 49, n);
    r2  = q54_mul(r, r);
    r3  = q54_mul(r2, r);
    r4  = q54_mul(r3, r);
    r5  = q54_mul(r4, r);
    e   = one - r + (r2 >> 1) - r3 / 64'd6 + r4 / 64'd24 - r5 / 64'd120;
    for (int k = 0; k < 8; k++) begin
      e = q54_mul(e, e);
    end
    num = (one - e) >> 10;
    den = (one + e) >> 10;
    return udiv64(num * 64'd32768 + (den >> 1), den);
  endfunction

  // One curve point: curve c at point s of a table of n points.
  function automatic logic signed [15:0] curve_entry(logic [63:0] n, logic c,
                                                     logic [63:0] s);
    logic        neg;
    logic [63:0] au;
    logic [63:0] mag;
    logic [63:0] negv;
    neg  = (64'd2 * s) < n;
    au   = neg ? (n - 64'd2 * s) : (64'd2 * s - n);
    mag  = c ? tanh_mag(au, n) : soft_clip_mag(au, n);
    negv = 64'd0 - mag;
    if (neg) begin
      return signed'(negv[15:0]);
    end
    if (mag > 64'd32767) begin
      return 16'sd32767;
    end
    return signed'(mag[15:0]);
  endfunction

endpackage

>>> design/tws_front.sv
// ============================================================================
// tws_front: position calculation and classification
// Scales each sample by the gain, maps it to a table position and sorts it
// into low saturation, high saturation or interpolation before queueing it.
// ============================================================================
module tws_front #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned IDX_W      = 10,
  parameter int unsigned ENTRY_W    = 40
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [15:0]       sample_in_i,
  input  logic [15:0]              input_gain_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output logic [ENTRY_W-1:0]       push_data_o
);

  localparam int unsigned FracW = tws_pkg::FracW;
  localparam int unsigned PosW  = 34 + $clog2(TABLE_SIZE);
  localparam int unsigned IntW  = PosW - FracW;
  localparam logic signed [32:0]     PosBias = 33'sd134217728;
  localparam logic signed [PosW-1:0] TsMul   = PosW'(TABLE_SIZE);
  localparam logic signed [PosW-1:0] OneStep = PosW'(64'd1 << FracW);
  localparam logic [IntW-1:0]        TopIdx  = IntW'(TABLE_SIZE - 1);

  logic                   s1_valid_q;
  logic signed [32:0]     s1_pos_q;
  logic signed [32:0]     s1_pos_d;
  logic signed [32:0]     gained;
  logic                   s1_ready;
  logic                   s2_valid_q;
  logic signed [PosW-1:0] s2_pos_q;
  logic signed [PosW-1:0] s2_pos_d;
  logic                   s2_ready;
  logic [IntW-1:0]        int_part;
  logic [IDX_W-1:0]       idx;
  tws_pkg::tws_kind_e     kind;

  // Gain multiply and offset by one full scale.
  assign gained   = $signed(sample_in_i) * $signed({1'b0, input_gain_i});
  assign s1_pos_d = gained + PosBias;
  assign s2_pos_d = PosW'(s1_pos_q) * TsMul;

  // Each stage advances when it is empty or its content moves on.
  assign s2_ready   = !s2_valid_q || push_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_pos_q <= s1_pos_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_pos_q <= s2_pos_d;
    end
  end

  // Classify the position against both ends of the table.
  assign int_part = s2_pos_q[PosW-1:FracW];

  always_comb begin
    if (s2_pos_q < OneStep) begin
      kind = tws_pkg::KIND_SAT_LO;
    end else if (int_part >= TopIdx) begin
      kind = tws_pkg::KIND_SAT_HI;
    end else begin
      kind = tws_pkg::KIND_INTERP;
    end
  end

  assign idx          = (kind == tws_pkg::KIND_INTERP) ? int_part[IDX_W-1:0] : '0;
  assign push_valid_o = s2_valid_q;
  assign push_data_o  = {kind, idx, s2_pos_q[FracW-1:0]};

endmodule

>>> design/tws_queue.sv
// ============================================================================
// tws_queue: short first-in first-out queue
// Decouples the front part from the back part so that each stalls alone.
// ============================================================================
module tws_queue #(
  parameter int unsigned DATA_W = 40,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] Full   = CntW'(DEPTH);
  localparam logic [PtrW-1:0] LastPt = PtrW'(DEPTH - 1);

  logic [DATA_W-1:0] slots_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = count_q != Full;
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPt) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPt) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> design/tws_back.sv
// ============================================================================
// tws_back: curve lookup and linear interpolation
// Reads two neighbouring points of the selected curve from the ROM, blends
// them by the fraction and rounds, or gives full scale for saturated items.
// ============================================================================
module tws_back #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned IDX_W      = 10,
  parameter int unsigned ENTRY_W    = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               curve_mode_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  logic [ENTRY_W-1:0] pop_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_out_o
);

  localparam int unsigned FracW = tws_pkg::FracW;
  localparam int unsigned AddrW = $clog2(2 * TABLE_SIZE);
  localparam logic [AddrW-1:0]   CurveBase = AddrW'(TABLE_SIZE);
  localparam logic signed [46:0] RoundBias = 47'sd134217728;

  typedef logic signed [15:0] rom_t [2*TABLE_SIZE];

  // Both curves, computed at elaboration.
  function automatic rom_t build_rom();
    rom_t rom;
    for (int s = 0; s < TABLE_SIZE; s++) begin
      rom[s]              = tws_pkg::curve_entry(64'(TABLE_SIZE), 1'b0, 64'(s));
      rom[TABLE_SIZE + s] = tws_pkg::curve_entry(64'(TABLE_SIZE), 1'b1, 64'(s));
    end
    return rom;
  endfunction

  localparam rom_t CurveRom = build_rom();

  tws_pkg::tws_kind_e pop_kind;
  logic [IDX_W-1:0]   pop_idx;
  logic [FracW-1:0]   pop_frac;
  logic [AddrW-1:0]   addr_lo;
  logic [AddrW-1:0]   addr_hi;

  logic                  b1_valid_q;
  tws_pkg::tws_kind_e    b1_kind_q;
  logic [FracW-1:0]      b1_frac_q;
  logic signed [15:0]    b1_t0_q;
  logic signed [15:0]    b1_t1_q;
  logic                  b1_ready;

  logic                  b2_valid_q;
  tws_pkg::tws_kind_e    b2_kind_q;
  logic signed [15:0]    b2_t0_q;
  logic signed [45:0]    b2_prod_q;
  logic signed [45:0]    b2_prod_d;
  logic signed [16:0]    slope;
  logic                  b2_ready;

  logic                  b3_valid_q;
  logic signed [15:0]    b3_out_q;
  logic signed [15:0]    b3_out_d;
  logic signed [46:0]    acc;
  logic                  b3_ready;

  // Unpack the queue entry and form both ROM addresses.
  assign pop_kind = tws_pkg::tws_kind_e'(pop_data_i[ENTRY_W-1 -: 2]);
  assign pop_idx  = pop_data_i[FracW +: IDX_W];
  assign pop_frac = pop_data_i[FracW-1:0];
  assign addr_lo  = AddrW'(pop_idx) + (curve_mode_i ? CurveBase : '0);
  assign addr_hi  = addr_lo + 1'b1;

  // Stage handshakes.
  assign b3_ready    = !b3_valid_q || out_ready_i;
  assign b2_ready    = !b2_valid_q || b3_ready;
  assign b1_ready    = !b1_valid_q || b2_ready;
  assign pop_ready_o = b1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_valid_q <= pop_valid_i;
      end
      if (b2_ready) begin
        b2_valid_q <= b1_valid_q;
      end
      if (b3_ready) begin
        b3_valid_q <= b2_valid_q;
      end
    end
  end

  // ROM read with registered data.
  always_ff @(posedge clk_i) begin
    if (b1_ready && pop_valid_i) begin
      b1_t0_q   <= CurveRom[addr_lo];
      b1_t1_q   <= CurveRom[addr_hi];
      b1_kind_q <= pop_kind;
      b1_frac_q <= pop_frac;
    end
  end

  // Fraction times the step between the two points.
  assign slope     = 17'(b1_t1_q) - 17'(b1_t0_q);
  assign b2_prod_d = $signed({1'b0, b1_frac_q}) * slope;

  always_ff @(posedge clk_i) begin
    if (b2_ready && b1_valid_q) begin
      b2_prod_q <= b2_prod_d;
      b2_t0_q   <= b1_t0_q;
      b2_kind_q <= b1_kind_q;
    end
  end

  // Add the base point, round half up and pick the saturated values.
  assign acc = (47'(b2_t0_q) <<< FracW) + 47'(b2_prod_q) + RoundBias;

  always_comb begin
    case (b2_kind_q)
      tws_pkg::KIND_SAT_LO: b3_out_d = 16'sh8000;
      tws_pkg::KIND_SAT_HI: b3_out_d = 16'sh7FFF;
      default:              b3_out_d = acc[FracW+15:FracW];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (b3_ready && b2_valid_q) begin
      b3_out_q <= b3_out_d;
    end
  end

  assign out_valid_o  = b3_valid_q;
  assign sample_out_o = b3_out_q;

endmodule

>>> design/table_waveshaper_interpolated_unit.sv
// Path: registered front stages, queue and back stages. Throughput: one sample
// per cycle unless out_ready_i stalls the output, set by the two-port curve ROM
// read and the single interpolation multiplier, both used once per sample.
// Reset: asynchronous and active low; clears the pipeline and queue, sets the
// soft-clip curve and unity gain. The curve ROM is constant and needs no pass.
// ============================================================================
// table_waveshaper_interpolated_unit: table waveshaper top level
// Holds the configuration registers and joins the front part, the queue and
// the back part of the waveshaper pipeline.
// ============================================================================
module table_waveshaper_interpolated_unit #(
  parameter int unsigned TABLE_SIZE = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tws_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [15:0]              sample_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [15:0]              sample_out_o
);

  localparam int unsigned IdxW   = $clog2(TABLE_SIZE);
  localparam int unsigned EntryW = 2 + IdxW + tws_pkg::FracW;

  logic              curve_mode_q;
  logic [15:0]       input_gain_q;
  logic              push_valid;
  logic              push_ready;
  logic [EntryW-1:0] push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [EntryW-1:0] pop_data;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_mode_q <= tws_pkg::CURVE_MODE_RESET;
      input_gain_q <= tws_pkg::INPUT_GAIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tws_pkg::CFG_CURVE_MODE: curve_mode_q <= cfg_data_i[0];
        tws_pkg::CFG_INPUT_GAIN: input_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tws_front #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IdxW),
    .ENTRY_W    (EntryW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .input_gain_i (input_gain_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  tws_queue #(
    .DATA_W (EntryW),
    .DEPTH  (tws_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tws_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IdxW),
    .ENTRY_W    (EntryW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .curve_mode_i (curve_mode_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

endmodule

>>> tb/sv/table_waveshaper_interpolated_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// table_waveshaper_interpolated_unit_tb: self-checking bench of the waveshaper
// Streams samples through the block under several curve and gain settings,
// predicts every shaped sample from a local copy of both transfer curves and
// compares each output transfer against the oldest prediction in order.
// ============================================================================
module table_waveshaper_interpolated_unit_tb;

  localparam int unsigned TBL_POINTS   = 1024;
  localparam int          FRAC_BITS    = 28;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          HOLD_CYCLES  = 150;
  localparam int          RAND_PHASES  = 8;
  localparam int          PHASE_ITEMS  = 200;
  localparam int unsigned CFG_IDX_W    = tws_pkg::CfgIndexW;

  // Highest index that maps to a real register; anything above is a spare.
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = tws_pkg::CFG_INPUT_GAIN;

  // How the output side paces its ready between long holds.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_PATTERN
  } rx_style_e;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [15:0]          cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic signed [15:0]   sample_in_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic signed [15:0]   sample_out_o;

  // Local copy of both curves and of the two registers.
  logic signed [15:0] curve_tbl [2*TBL_POINTS];
  logic               shp_mode;
  logic [15:0]        shp_gain;

  // Samples waiting to be offered, and shaped samples waiting to come out.
  logic signed [15:0] drive_q [$];
  logic signed [15:0] shaped_q [$];

  int n_queued;
  int n_results;
  int n_errors;
  int n_settings;
  int n_holds;
  int n_in_stalls;
  int cycle_cnt;

  int edge_samples [12] = '{-32768, -32705, -32704, -1, 0, 1, 32, -32, 96,
                            32703, 32704, 32767};

  table_waveshaper_interpolated_unit #(
    .TABLE_SIZE(TBL_POINTS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o)
  );

  // Free-running clock.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Curve construction
  // ---------------------------------------------------------------------------

  // Product of two Q54 numbers, truncated to Q54 and to 64 bits.
  function automatic longint unsigned prod_q54(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[117:54];
  endfunction

  // Soft-clip magnitude in Q15 at |x| = au/n, computed exactly in integers.
  function automatic longint clip_curve_q15(longint unsigned au, longint unsigned n);
    longint unsigned d;
    longint unsigned den;
    if (3 * au > 2 * n) begin
      return 32768;
    end
    if (3 * au > n) begin
      d   = 2 * n - 3 * au;
      den = 3 * n * n;
      return 32768 - longint'((64'd32768 * d * d + den / 2) / den);
    end
    return longint'((64'd65536 * au + n / 2) / n);
  endfunction

  // Magnitude of tanh(4x) in Q15 at |x| = au/n, via exp(-8x) = exp(-8x/256)^256.
  function automatic longint tanh_curve_q15(longint unsigned au, longint unsigned n);
    longint unsigned unity;
    longint unsigned r;
    longint unsigned r2;
    longint unsigned r3;
    longint unsigned r4;
    longint unsigned r5;
    longint unsigned ex;
    longint unsigned num;
    longint unsigned den;
    unity = 64'd1 << 54;
    r     = (au << 49) / n;
    r2    = prod_q54(r, r);
    r3    = prod_q54(r2, r);
    r4    = prod_q54(r3, r);
    r5    = prod_q54(r4, r);
    ex    = unity - r + r2 / 2 - r3 / 6 + r4 / 24 - r5 / 120;
    for (int k = 0; k < 8; k++) begin
      ex = prod_q54(ex, ex);
    end
    num = (unity - ex) >> 10;
    den = (unity + ex) >> 10;
    return longint'((num * 64'd32768 + den / 2) / den);
  endfunction

  // Applies the sign and clamps to the Q1.15 range.
  function automatic logic signed [15:0] sat_q15(longint mag, bit neg);
    longint v;
    v = neg ? -mag : mag;
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return v[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Mirrors a register write, ignoring spare indexes and unused data bits.
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      tws_pkg::CFG_CURVE_MODE: begin
        shp_mode = data[0];
      end
      tws_pkg::CFG_INPUT_GAIN: begin
        shp_gain = data;
      end
      default: begin
      end
    endcase
  endfunction

  // Shapes one sample with the current curve and gain.
  function automatic logic signed [15:0] shape_sample(logic signed [15:0] smp);
    longint pos;
    longint idx;
    longint frac;
    longint lo_pt;
    longint hi_pt;
    longint acc;
    longint res;
    int     base;
    pos = (longint'(smp) * longint'(shp_gain) + (64'sd1 <<< 27)) * TBL_POINTS;
    if (pos < (64'sd1 <<< FRAC_BITS)) begin
      return -16'sd32768;
    end
    idx  = pos >>> FRAC_BITS;
    frac = pos & ((64'sd1 <<< FRAC_BITS) - 1);
    if (idx >= TBL_POINTS - 1) begin
      return 16'sd32767;
    end
    base  = shp_mode ? TBL_POINTS : 0;
    lo_pt = longint'(curve_tbl[base + int'(idx)]);
    hi_pt = longint'(curve_tbl[base + int'(idx) + 1]);
    acc   = ((64'sd1 <<< FRAC_BITS) - frac) * lo_pt + frac * hi_pt;
    // Round to nearest, ties toward plus infinity.
    res   = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return res[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Random sample, biased toward the interpolating region, the saturation
  // edges and samples that land half way between two points at unity gain.
  function automatic logic signed [15:0] pick_sample(logic [15:0] gain);
    int reach;
    int v;
    reach = (gain == 0) ? 32767 : (1 << 27) / int'(gain);
    if (reach > 32767) begin
      reach = 32767;
    end
    case ($urandom_range(0, 9))
      6, 7: begin
        v = int'($urandom_range(0, 2 * reach)) - reach;
      end
      8: begin
        v = int'($urandom_range(0, 1023)) * 64 + 32 - 32768;
      end
      9: begin
        v = ($urandom_range(0, 1) ? reach : -reach) + int'($urandom_range(0, 4)) - 2;
      end
      default: begin
        v = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return v[15:0];
  endfunction

  task automatic queue_sample(logic signed [15:0] smp);
    drive_q.push_back(smp);
    n_queued++;
  endtask

  // Waits until every queued sample has come back shaped.
  task automatic finish_phase();
    while (n_results < n_queued) begin
      @(posedge clk_i);
    end
  endtask

  // One register write transfer; the mirror follows at the transfer edge.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    apply_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic cfg_setting(logic mode, logic [15:0] gain);
    logic [CFG_IDX_W-1:0] spare;
    spare = CFG_IDX_W'($urandom_range(int'(CFG_LAST_INDEX) + 1, (1 << CFG_IDX_W) - 1));
    cfg_write(tws_pkg::CFG_INPUT_GAIN, gain);
    cfg_write(spare, 16'($urandom));
    // Upper data bits of the curve select are random and must be ignored.
    cfg_write(tws_pkg::CFG_CURVE_MODE, {15'($urandom), mode});
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bit              neg;
    longint unsigned au;
    logic            mode;
    logic [15:0]     gain;
    for (int s = 0; s < TBL_POINTS; s++) begin
      neg = (2 * s) < TBL_POINTS;
      au  = neg ? longint'(TBL_POINTS - 2 * s) : longint'(2 * s - TBL_POINTS);
      curve_tbl[s]              = sat_q15(clip_curve_q15(au, TBL_POINTS), neg);
      curve_tbl[TBL_POINTS + s] = sat_q15(tanh_curve_q15(au, TBL_POINTS), neg);
    end
    shp_mode = tws_pkg::CURVE_MODE_RESET;
    shp_gain = tws_pkg::INPUT_GAIN_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: full-scale extremes, both saturation boundaries,
    // exact table points and half-way points.
    n_settings = 1;
    foreach (edge_samples[i]) begin
      queue_sample(16'(edge_samples[i]));
    end
    finish_phase();

    // Zero gain maps every sample onto the table centre.
    cfg_setting(1'b1, 16'd0);
    queue_sample(-16'sd32768);
    queue_sample(16'sd32767);
    finish_phase();

    // Largest gain on the tanh curve.
    cfg_setting(1'b1, 16'hFFFF);
    queue_sample(-16'sd32768);
    queue_sample(-16'sd1);
    queue_sample(16'sd0);
    queue_sample(16'sd1);
    queue_sample(16'sd32767);
    finish_phase();

    // Random phases, the first four on fixed corner settings.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          mode = 1'b0;
          gain = 16'hFFFF;
        end
        1: begin
          mode = 1'b1;
          gain = 16'd1;
        end
        2: begin
          mode = 1'b0;
          gain = 16'd0;
        end
        3: begin
          mode = 1'b1;
          gain = tws_pkg::INPUT_GAIN_RESET;
        end
        default: begin
          mode = 1'($urandom);
          gain = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(2048, 12288));
        end
      endcase
      cfg_setting(mode, gain);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        queue_sample(pick_sample(gain));
      end
      finish_phase();
    end

    // Catch any stray output after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shaped_q.size() != 0) begin
      $error("sample_out: %0d expected results never arrived", shaped_q.size());
      n_errors++;
    end
    $display("Shaped %0d samples under %0d curve and gain settings in %0d cycles.",
             n_results, n_settings, cycle_cnt);
    $display("Output held back %0d times; input stalled on %0d cycles.",
             n_holds, n_in_stalls);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sample driver: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin : sample_driver
    logic               nxt_valid;
    logic signed [15:0] nxt_sample;
    nxt_valid  = in_valid_i;
    nxt_sample = sample_in_i;
    // A completed input transfer produces one prediction.
    if (in_valid_i && in_ready_o) begin
      shaped_q.push_back(shape_sample(sample_in_i));
      nxt_valid = 1'b0;
    end
    if (in_valid_i && !in_ready_o) begin
      n_in_stalls++;
    end
    // Offer the next sample once the slot is free and no gap is running.
    if (!nxt_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (drive_q.size() > 0) begin
        nxt_sample = drive_q.pop_front();
        nxt_valid  = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
    end
    in_valid_i  <= nxt_valid;
    sample_in_i <= nxt_sample;
  end

  // ---------------------------------------------------------------------------
  // Result monitor and output pacing, with occasional long holds.
  // ---------------------------------------------------------------------------
  rx_style_e rx_style     = RX_ALWAYS;
  int        rx_cycles    = 0;
  int        hold_left    = 0;
  int        next_hold_at = 300;

  always @(posedge clk_i) begin : result_monitor
    logic signed [15:0] want;
    logic               nxt_ready;
    // Check each output transfer against the oldest prediction.
    if (out_valid_o && out_ready_i) begin
      if (shaped_q.size() == 0) begin
        $error("sample_out: expected nothing, actual %0d", sample_out_o);
        n_errors++;
      end else begin
        want = shaped_q.pop_front();
        if (sample_out_o !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, sample_out_o);
          n_errors++;
        end
      end
      n_results++;
    end
    // Start a long hold while samples are still being offered.
    rx_cycles++;
    if (hold_left == 0 && n_results >= next_hold_at && in_valid_i) begin
      hold_left    = HOLD_CYCLES;
      next_hold_at = next_hold_at + 500;
      n_holds++;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else begin
      if (rx_cycles % 64 == 0) begin
        rx_style = rx_style_e'($urandom_range(0, 3));
      end
      case (rx_style)
        RX_ALWAYS: begin
          nxt_ready = 1'b1;
        end
        RX_RANDOM: begin
          nxt_ready = 1'($urandom);
        end
        RX_SPARSE: begin
          nxt_ready = ($urandom_range(0, 3) == 0);
        end
        default: begin
          nxt_ready = (rx_cycles % 8) < 5;
        end
      endcase
    end
    out_ready_i <= nxt_ready;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d of %0d results seen.",
               CYCLE_LIMIT, n_results, n_queued);
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
